### sv/csrw_pkg.sv
// ----------------------------------------------------------------------------
// csrw_pkg
// Shared constants, codes and controller/datapath interface types for the
// counting semaphore with randomized wake.
// ----------------------------------------------------------------------------
package csrw_pkg;

    localparam int MAX_WAITERS  = 16;
    localparam int TASK_ID_BITS = 8;

    localparam int TASK_ID_W = 8;
    localparam int STORE_W   = (TASK_ID_BITS < TASK_ID_W) ? TASK_ID_BITS : TASK_ID_W;
    localparam int WCNT_W    = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W     = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int PICK_W    = 16;
    localparam int PICK_BIT_W = $clog2(PICK_W);
    localparam int CNT_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic OP_WAIT   = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    localparam logic REG_INIT_COUNT = 1'b0;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_signal;
        logic div_busy;
    } t_dp_stat;

endpackage

### sv/csrw_mod.sv
// ----------------------------------------------------------------------------
// csrw_mod
// Bit-serial restoring remainder unit: pick mod waiter count, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module csrw_mod
    import csrw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PICK_W-1:0] i_dividend,
    input  logic [WCNT_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [WCNT_W-1:0] o_rem
);

    localparam logic [PICK_BIT_W-1:0] BIT_LAST = PICK_BIT_W'(PICK_W - 1);

    logic                  r_busy;
    logic [PICK_BIT_W-1:0] r_bit;
    logic [PICK_W-1:0]     r_dvd;
    logic [WCNT_W-1:0]     r_div;
    logic [WCNT_W-1:0]     r_rem;
    logic [WCNT_W:0]       trial;
    logic [WCNT_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[PICK_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = WCNT_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[WCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_bit  <= '0;
        end else if (r_busy) begin
            r_bit <= r_bit + 1'b1;
            if (r_bit == BIT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[PICK_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

### sv/csrw_dp.sv
// ----------------------------------------------------------------------------
// csrw_dp
// Datapath: semaphore count, ordered waiter list, remainder unit, result
// registers and the configuration register.
// ----------------------------------------------------------------------------
module csrw_dp
    import csrw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_opcode,
    input  logic [TASK_ID_W-1:0]    i_task_id,
    input  logic [PICK_W-1:0]       i_pick,
    output logic                    o_caller_sleeps,
    output logic                    o_woke_valid,
    output logic [TASK_ID_W-1:0]    o_woke_task,
    output logic signed [CNT_W-1:0] o_count_after,
    output logic [STATUS_W-1:0]     o_status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata
);

    logic signed [CNT_W-1:0] r_count;
    logic [WCNT_W-1:0]       r_total;
    logic [STORE_W-1:0]      r_ids [MAX_WAITERS];
    logic signed [CNT_W-1:0] r_cfg_init;
    logic                    r_op;
    logic [STORE_W-1:0]      r_tid;

    logic                    r_o_sleeps;
    logic                    r_o_wvalid;
    logic [STORE_W-1:0]      r_o_wtask;
    logic signed [CNT_W-1:0] r_o_count;
    logic [STATUS_W-1:0]     r_o_status;

    logic                    cfg_write;
    logic                    div_busy;
    logic [WCNT_W-1:0]       div_rem;
    logic [IDX_W-1:0]        pos;
    logic                    list_full;
    logic                    dec_sat;
    logic signed [CNT_W-1:0] dec_val;
    logic                    inc_sat;

    logic                    n_sleeps;
    logic                    n_wake;
    logic [STORE_W-1:0]      n_wtask;
    logic signed [CNT_W-1:0] n_count;
    logic [STATUS_W-1:0]     n_status;

    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_INIT_COUNT);
    assign prdata    = (paddr[2] == REG_INIT_COUNT) ? APB_DW'(r_cfg_init) : '0;

    csrw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.capture && (i_opcode == OP_SIGNAL)),
        .i_dividend (i_pick),
        .i_divisor  (r_total),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    assign o_stat.in_signal = (i_opcode == OP_SIGNAL);
    assign o_stat.div_busy  = div_busy;

    assign pos       = div_rem[IDX_W-1:0];
    assign list_full = (r_total >= WCNT_W'(MAX_WAITERS));
    assign dec_sat   = (r_count == CNT_MIN);
    assign dec_val   = dec_sat ? CNT_MIN : r_count - 16'sd1;
    assign inc_sat   = (r_count == CNT_MAX);

    always_comb begin
        n_sleeps = 1'b0;
        n_wake   = 1'b0;
        n_wtask  = '0;
        n_count  = r_count;
        n_status = ST_OK;
        if (r_op == OP_WAIT) begin
            if (dec_val < 0) begin
                if (list_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_sleeps = 1'b1;
                    n_count  = dec_val;
                    n_status = dec_sat ? ST_SAT : ST_OK;
                end
            end else begin
                n_count = dec_val;
            end
        end else begin
            if (inc_sat) begin
                n_status = ST_SAT;
            end else begin
                n_count = r_count + 16'sd1;
            end
            if (r_total != '0) begin
                n_wake  = 1'b1;
                n_wtask = r_ids[pos];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_total    <= '0;
            r_cfg_init <= '0;
        end else if (cfg_write) begin
            r_count    <= pwdata[CNT_W-1:0];
            r_total    <= '0;
            r_cfg_init <= pwdata[CNT_W-1:0];
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            if (n_sleeps) begin
                r_total <= r_total + 1'b1;
            end else if (n_wake) begin
                r_total <= r_total - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_tid <= i_task_id[STORE_W-1:0];
        end
        if (i_cmd.commit) begin
            r_o_sleeps <= n_sleeps;
            r_o_wvalid <= n_wake;
            r_o_wtask  <= n_wtask;
            r_o_count  <= n_count;
            r_o_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_sleeps) begin
            r_ids[r_total[IDX_W-1:0]] <= r_tid;
        end
        for (int i = 0; i < MAX_WAITERS - 1; i++) begin
            if (i_cmd.commit && n_wake && (IDX_W'(i) >= pos)) begin
                r_ids[i] <= r_ids[i+1];
            end
        end
    end

    assign o_caller_sleeps = r_o_sleeps;
    assign o_woke_valid    = r_o_wvalid;
    assign o_woke_task     = TASK_ID_W'(r_o_wtask);
    assign o_count_after   = r_o_count;
    assign o_status        = r_o_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= WCNT_W'(MAX_WAITERS))
        else $error("waiter total above list depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !cfg_write && n_wake) |=> (r_total == $past(r_total) - 1'b1))
        else $error("wake did not shrink the waiter list");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_wake) |-> (!div_busy && (div_rem < r_total)))
        else $error("wake position outside the waiter list");

endmodule

### sv/csrw_ctrl.sv
// ----------------------------------------------------------------------------
// csrw_ctrl
// Controller: input and output handshakes, sequencing of capture, remainder
// and commit.
// ----------------------------------------------------------------------------
module csrw_ctrl
    import csrw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;

    assign o_cmd.capture = accept;
    assign o_cmd.commit  = (r_state == S_EXEC) && slot_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.in_signal ? S_DIV : S_EXEC;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_valid)
        else $error("commit did not present a result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("second transaction taken before the first finished");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && !slot_free) |=> (r_state == S_EXEC))
        else $error("execute left while the result slot was occupied");

endmodule

### sv/counting_semaphore_random_wake_top.sv
// ----------------------------------------------------------------------------
// counting_semaphore_random_wake_top
// Counting semaphore with an ordered waiter list and randomized wake.
// ----------------------------------------------------------------------------
// A wait transaction is accepted and then goes to the update step, which
// changes the count and the waiter list. A signal transaction is accepted,
// then waits in the bit-serial remainder unit that reduces pick modulo the
// waiter count until the controller sees that unit finish, and then goes to
// the update step, which changes the count and closes the gap in the waiter
// list. A new transaction is accepted only after the update step. The next
// transaction is accepted while a finished result still waits in the output
// register; its update step then stalls until that result is taken. A write
// to initial_count reloads the count and empties the list; write it only
// while the block is idle.
module counting_semaphore_random_wake_top
    import csrw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_opcode,
    input  logic [TASK_ID_W-1:0]    i_task_id,
    input  logic [PICK_W-1:0]       i_pick,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_caller_sleeps,
    output logic                    o_woke_valid,
    output logic [TASK_ID_W-1:0]    o_woke_task,
    output logic signed [CNT_W-1:0] o_count_after,
    output logic [STATUS_W-1:0]     o_status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign pready = 1'b1;

    csrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    csrw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_pick          (i_pick),
        .o_caller_sleeps (o_caller_sleeps),
        .o_woke_valid    (o_woke_valid),
        .o_woke_task     (o_woke_task),
        .o_count_after   (o_count_after),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata)
    );

endmodule
